FILE: rtl/acs_pkg.sv
// acs_pkg: shared types and constants for the accumulator cpu step block
// used by the top level and its port checker; no dependencies
`default_nettype none

package acs_pkg;

    // memory geometry and data width
    localparam int DATA_W    = 8;
    localparam int MEM_DEPTH = 32;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // beat action carried on s_tuser
    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // instruction opcode, top three bits of the instruction byte
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_STORE = 3'd1,
        OP_SKIP  = 3'd2,
        OP_JUMP  = 3'd3,
        OP_ADD   = 3'd4,
        OP_NEG   = 3'd5,
        OP_AND   = 3'd6,
        OP_NOT   = 3'd7
    } opcode_t;

    // item sequencer
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_OPER   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/accumulator_cpu_step.sv
// accumulator_cpu_step: 8-bit accumulator processor with a 32-byte unified memory
// depends on acs_pkg and acs_ram
//
//  channel | direction | tdata (low bit up)                          | tuser
//  s_      | in        | address[4:0] write_data[12:5] zero[15:13]   | action[1:0]
//  m_      | out       | accumulator[7:0] program_counter[12:8]      | -
//          |           | read_data[20:13] skip_taken[21] zero[23:22] |
//
// an item passes through the accept step, which issues the first ram read, then the
// operand read, then compute and write back, after which the result register loads.
// the next beat is accepted in the last cycle of the one before, so a new beat is
// taken while the previous one finishes; beat spacing is set by the instruction fetch
// and the dependent operand read on the single ram read port.
// reset clears 32 per-byte valid flops so unwritten bytes read as zero; no clearing pass.
// a result held on m_ stalls the final step, and s_tready drops with it.
`default_nettype none

module accumulator_cpu_step import acs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // address[4:0], write_data[12:5], zero[15:13]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // accumulator[7:0], program_counter[12:8],
                                        // read_data[20:13], skip_taken[21], zero[23:22]
);

    state_t state_reg, state_next;

    logic [1:0]           act_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    wdata_reg;
    logic [DATA_W-1:0]    first_reg;
    logic [DATA_W-1:0]    acc_reg;
    logic [ADDR_W-1:0]    pc_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic                 rvalid_reg;
    logic                 byp_hit_reg;
    logic [DATA_W-1:0]    byp_data_reg;

    logic                 m_valid_reg;
    logic [DATA_W-1:0]    m_acc_reg;
    logic [ADDR_W-1:0]    m_pc_reg;
    logic [DATA_W-1:0]    m_rdata_reg;
    logic                 m_skip_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]    ram_rdata;

    logic                 out_free;
    logic                 finishing;
    logic                 s_accept;
    logic [ADDR_W-1:0]    in_address;
    logic [DATA_W-1:0]    in_wdata;
    logic [DATA_W-1:0]    rd_eff;
    logic [ADDR_W-1:0]    pc_fetch;
    logic [ADDR_W-1:0]    fetch_addr;

    logic [DATA_W-1:0]    acc_new;
    logic [ADDR_W-1:0]    pc_new;
    logic                 skip_new;
    logic [DATA_W-1:0]    rdata_new;
    logic                 we_new;
    logic [ADDR_W-1:0]    waddr_new;
    logic [DATA_W-1:0]    wdata_new;
    opcode_t              op;
    logic [ADDR_W-1:0]    idx;

    // handshake
    assign out_free   = !m_valid_reg || m_tready;
    assign finishing  = (state_reg == ST_FINISH) && out_free;
    assign s_tready   = (state_reg == ST_IDLE) || finishing;
    assign s_accept   = s_tvalid && s_tready;
    assign in_address = s_tdata[ADDR_W-1:0];
    assign in_wdata   = s_tdata[ADDR_W+DATA_W-1:ADDR_W];

    // read data with same-cycle write bypass; unwritten bytes read as zero
    assign rd_eff = byp_hit_reg ? byp_data_reg : (rvalid_reg ? ram_rdata : '0);

    // final step: execute, write or read
    assign op  = opcode_t'(first_reg[DATA_W-1:DATA_W-3]);
    assign idx = first_reg[ADDR_W-1:0];

    always_comb begin
        acc_new   = acc_reg;
        pc_new    = pc_reg;
        skip_new  = 1'b0;
        rdata_new = '0;
        we_new    = 1'b0;
        waddr_new = addr_reg;
        wdata_new = wdata_reg;
        case (act_reg)
            ACT_EXEC: begin
                rdata_new = first_reg;
                pc_new    = pc_reg + ADDR_W'(1);
                case (op)
                    OP_LOAD:  acc_new = rd_eff;
                    OP_STORE: begin
                        we_new    = 1'b1;
                        waddr_new = idx;
                        wdata_new = acc_reg;
                    end
                    OP_SKIP: begin
                        if (acc_reg == rd_eff) begin
                            skip_new = 1'b1;
                            pc_new   = pc_reg + ADDR_W'(2);
                        end
                    end
                    OP_JUMP:  pc_new  = idx;
                    OP_ADD:   acc_new = acc_reg + rd_eff;
                    OP_NEG:   acc_new = '0 - acc_reg;
                    OP_AND:   acc_new = acc_reg & rd_eff;
                    OP_NOT:   acc_new = ~acc_reg;
                    default:  acc_new = acc_reg;
                endcase
            end
            ACT_WRITE: we_new    = 1'b1;
            ACT_READ:  rdata_new = first_reg;
            default:   rdata_new = '0;
        endcase
    end

    // ram ports: write only when the final step completes
    assign ram_we    = finishing && we_new;
    assign ram_waddr = waddr_new;
    assign ram_wdata = wdata_new;

    // fetch uses the pc the finishing item leaves behind
    assign pc_fetch   = finishing ? pc_new : pc_reg;
    assign fetch_addr = (s_tuser == ACT_EXEC) ? pc_fetch : in_address;

    always_comb begin
        case (state_reg)
            ST_IDLE:   ram_raddr = fetch_addr;
            ST_OPER:   ram_raddr = rd_eff[ADDR_W-1:0];
            ST_FINISH: ram_raddr = s_accept ? fetch_addr : idx;
            default:   ram_raddr = fetch_addr;
        endcase
    end

    acs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_OPER;
            ST_OPER:   state_next = ST_FINISH;
            ST_FINISH: begin
                if (finishing) begin
                    state_next = s_accept ? ST_OPER : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            pc_reg      <= '0;
            valid_reg   <= '0;
            byp_hit_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            byp_hit_reg <= ram_we && (ram_waddr == ram_raddr);
            rvalid_reg  <= valid_reg[ram_raddr];
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (finishing) begin
                acc_reg     <= acc_new;
                pc_reg      <= pc_new;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byp_data_reg <= ram_wdata;
        if (s_accept) begin
            act_reg   <= s_tuser;
            addr_reg  <= in_address;
            wdata_reg <= in_wdata;
        end
        if (state_reg == ST_OPER) begin
            first_reg <= rd_eff;
        end
        if (finishing) begin
            m_acc_reg   <= acc_new;
            m_pc_reg    <= pc_new;
            m_rdata_reg <= rdata_new;
            m_skip_reg  <= skip_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_skip_reg, m_rdata_reg, m_pc_reg, m_acc_reg};

endmodule

`default_nettype wire

FILE: rtl/acs_ram.sv
// acs_ram: generic single write port, single read port ram with registered read
// no package dependency
`default_nettype none

module acs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/acs_checker.sv
// acs_checker: port-level checks for accumulator_cpu_step, bound to the top level
// depends on acs_pkg
`default_nettype none

module acs_checker import acs_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a waiting input beat keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input beat changed while waiting");

    // no result is pending right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the operand read keeps the input closed in the cycle after each beat
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beats accepted back to back");

    // a taken skip only comes from a skip-if-equal instruction
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> opcode_t'(m_tdata[20:18]) == OP_SKIP)
        else $error("skip flag on a non-skip instruction");

endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (.*);

`default_nettype wire
